FILE: sv/ahrs_pkg.sv
// ----------------------------------------------------------------------------
// ahrs_pkg
// Shared constants and types of the AHRS frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ahrs_pkg;

    localparam int FRAME_BYTES     = 30;
    localparam int POS_W           = 5;
    localparam int NUM_WORDS       = 10;
    localparam int WORD_IDX_W      = 4;
    localparam int LAST_MOTION_POS = 18;
    localparam int TEMP_HIGH_POS   = 25;
    localparam int TEMP_LOW_POS    = 26;
    localparam logic [7:0] SYNC_RESET = 8'hFF;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_LAST  = 2'd1,
        OP_ABORT = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_BAD_SUM   = 2'd1,
        ST_SHORT     = 2'd2
    } t_status;

    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } t_op_item;

endpackage

`default_nettype wire

FILE: sv/ahrs_if.sv
// ----------------------------------------------------------------------------
// ahrs_if
// Channel interfaces: link bytes in, decoded frames out, sync register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ahrs_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, kind, data_byte, input ready);
    modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface ahrs_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [15:0] temperature_code;
    logic        [1:0]  status;

    modport source (output valid, roll, pitch, yaw, roll_rate, pitch_rate, yaw_rate,
                    accel_x, accel_y, accel_z, temperature_code, status,
                    input ready);
    modport sink   (input valid, roll, pitch, yaw, roll_rate, pitch_rate, yaw_rate,
                    accel_x, accel_y, accel_z, temperature_code, status,
                    output ready);
endinterface

interface ahrs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: sv/ahrs_front.sv
// ----------------------------------------------------------------------------
// ahrs_front
// Hunts for the sync byte, tracks frame position and classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ahrs_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ahrs_in_if.sink             i_in,
    ahrs_cfg_if.sink            i_cfg,
    input  wire logic           i_full,
    output logic                o_push,
    output ahrs_pkg::t_op_item  o_item
);
    import ahrs_pkg::*;

    logic [7:0]       r_sync;
    logic             r_in_frame;
    logic             n_in_frame;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic             w_take;
    logic             w_last;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign w_take      = i_in.valid && !i_full;
    assign w_last      = (r_pos >= POS_W'(FRAME_BYTES - 1));

    always_comb begin
        n_in_frame  = r_in_frame;
        n_pos       = r_pos;
        o_push      = 1'b0;
        o_item.op   = OP_DATA;
        o_item.pos  = r_pos;
        o_item.data = i_in.data_byte;
        if (w_take) begin
            if (i_in.kind) begin
                // abort while hunting is dropped
                if (r_in_frame) begin
                    o_push     = 1'b1;
                    o_item.op  = OP_ABORT;
                    n_in_frame = 1'b0;
                    n_pos      = '0;
                end
            end else if (!r_in_frame) begin
                if (i_in.data_byte == r_sync) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_W'(1);
                end
            end else begin
                o_push = 1'b1;
                if (w_last) begin
                    o_item.op  = OP_LAST;
                    n_in_frame = 1'b0;
                    n_pos      = '0;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync     <= SYNC_RESET;
            r_in_frame <= 1'b0;
            r_pos      <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_sync <= i_cfg.data;
            end
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
        end
    end

endmodule

`default_nettype wire

FILE: sv/ahrs_opq.sv
// ----------------------------------------------------------------------------
// ahrs_opq
// Short queue of classified bytes between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module ahrs_opq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire ahrs_pkg::t_op_item  i_item,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output ahrs_pkg::t_op_item       o_item
);
    import ahrs_pkg::*;

    t_op_item           r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               w_wr;
    logic               w_rd;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: sv/ahrs_back.sv
// ----------------------------------------------------------------------------
// ahrs_back
// Captures words, keeps the running sum and builds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ahrs_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_empty,
    input  wire ahrs_pkg::t_op_item  i_item,
    output logic                     o_pop,
    ahrs_res_if.source               o_res
);
    import ahrs_pkg::*;

    logic [7:0]  r_hold;
    logic [7:0]  n_hold;
    logic [7:0]  r_sum;
    logic [7:0]  n_sum;
    logic [15:0] r_words [NUM_WORDS];
    logic [15:0] n_words [NUM_WORDS];
    logic        r_valid;
    logic        w_out_free;
    logic        w_emit;
    logic [WORD_IDX_W-1:0] w_idx;
    logic [15:0] r_out_words [NUM_WORDS];
    t_status     r_status;

    assign w_out_free = !r_valid || o_res.ready;
    // data bytes never stall; a frame end waits for the result register
    assign o_pop  = !i_empty && ((i_item.op == OP_DATA) || w_out_free);
    assign w_emit = o_pop && (i_item.op != OP_DATA);
    assign w_idx  = WORD_IDX_W'(i_item.pos[POS_W-1:1]) - 1'b1;

    always_comb begin
        n_hold  = r_hold;
        n_sum   = r_sum;
        n_words = r_words;
        if (o_pop && i_item.op != OP_ABORT) begin
            if (i_item.pos inside {[1:LAST_MOTION_POS]}) begin
                if (i_item.pos[0]) begin
                    n_hold = i_item.data;
                end else begin
                    n_words[w_idx] = {r_hold, i_item.data};
                end
            end else if (i_item.pos == POS_W'(TEMP_HIGH_POS)) begin
                n_hold = i_item.data;
            end else if (i_item.pos == POS_W'(TEMP_LOW_POS)) begin
                n_words[NUM_WORDS-1] = {r_hold, i_item.data};
            end
        end
        if (o_pop) begin
            if (i_item.op == OP_DATA) begin
                n_sum = r_sum + i_item.data;
            end else begin
                n_sum = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_words <= n_words;
        if (w_emit) begin
            if (i_item.op == OP_LAST) begin
                r_out_words <= n_words;
                r_status    <= (r_sum == i_item.data) ? ST_GOOD : ST_BAD_SUM;
            end else begin
                for (int j = 0; j < NUM_WORDS; j++) begin
                    r_out_words[j] <= '0;
                end
                r_status <= ST_SHORT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold  <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_hold <= n_hold;
            r_sum  <= n_sum;
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.roll             = $signed(r_out_words[0]);
    assign o_res.pitch            = $signed(r_out_words[1]);
    assign o_res.yaw              = $signed(r_out_words[2]);
    assign o_res.roll_rate        = $signed(r_out_words[3]);
    assign o_res.pitch_rate       = $signed(r_out_words[4]);
    assign o_res.yaw_rate         = $signed(r_out_words[5]);
    assign o_res.accel_x          = $signed(r_out_words[6]);
    assign o_res.accel_y          = $signed(r_out_words[7]);
    assign o_res.accel_z          = $signed(r_out_words[8]);
    assign o_res.temperature_code = r_out_words[NUM_WORDS-1];
    assign o_res.status           = r_status;

endmodule

`default_nettype wire

FILE: sv/ahrs_frame_decoder_core.sv
// The closing byte or abort passes through the op queue into the registered result.
// Throughput: one link byte per cycle while results are taken, sustained by the two-entry op
//   queue and the result register, which is reloaded in the same cycle it is taken.
// A frame end waits in the queue only while an earlier result is still held.
// Reset (synchronous, active low) starts hunting, clears the sum and sets sync to 0xFF.
// ----------------------------------------------------------------------------
// ahrs_frame_decoder_core
// Sync-byte framed AHRS decoder with additive 8-bit checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module ahrs_frame_decoder_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ahrs_in_if.sink    i_in,
    ahrs_cfg_if.sink   i_cfg,
    ahrs_res_if.source o_res
);
    import ahrs_pkg::*;

    logic     w_push;
    logic     w_full;
    logic     w_pop;
    logic     w_empty;
    t_op_item w_push_item;
    t_op_item w_head_item;

    ahrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    ahrs_opq u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_head_item)
    );

    ahrs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_item  (w_head_item),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AHRS frame decoder core. Link bytes and aborts
// go in through a valid/ready channel. A scoreboard decodes the same byte
// stream on its own and compares every frame result field by field. Both
// sides idle at random, the receiver holds off once for a long stretch, and
// the sync register changes between phases.
// ----------------------------------------------------------------------------

module tb_top;
    import ahrs_pkg::*;

    localparam logic KIND_DATA       = 1'b0;
    localparam logic KIND_ABORT      = 1'b1;
    localparam int   CYCLE_LIMIT     = 400000;
    localparam int   DRAIN_CYCLES    = 8;
    localparam int   HOLD_OFF_CYCLES = 400;
    localparam int   HOLD_AFTER_RES  = 20;
    localparam int   PHASE_ITEMS     = 270;
    localparam int   NUM_PHASES      = 6;

    localparam int STYLE_RANDOM  = 0;
    localparam int STYLE_PATTERN = 1;
    localparam int STYLE_ALLSYNC = 2;

    typedef struct {
        logic [15:0] word [NUM_WORDS];
        t_status     status;
    } decoded_t;

    class frame_scoreboard;
        logic [7:0]       sync_val;
        logic [POS_W-1:0] pos;
        bit               in_frame;
        logic [7:0]       sum;
        logic [7:0]       hold;
        logic [15:0]      words [NUM_WORDS];
        decoded_t         pending [$];
        int               errors;
        string            names [NUM_WORDS];

        function new();
            names = '{"roll", "pitch", "yaw", "roll_rate", "pitch_rate", "yaw_rate",
                      "accel_x", "accel_y", "accel_z", "temperature_code"};
            errors   = 0;
            sync_val = SYNC_RESET;
            pos      = '0;
            in_frame = 1'b0;
            sum      = 8'h00;
            hold     = 8'h00;
            foreach (words[i]) words[i] = 16'h0000;
        endfunction

        function void set_sync(logic [7:0] v);
            sync_val = v;
        endfunction

        // queue one frame result and go back to hunting
        function void close_frame(bit with_data, t_status st);
            decoded_t d;
            foreach (d.word[i]) d.word[i] = with_data ? words[i] : 16'h0000;
            d.status = st;
            pending.push_back(d);
            in_frame = 1'b0;
            pos      = '0;
            sum      = 8'h00;
        endfunction

        // returns 1 when the transfer took part in a frame
        function bit note_input(logic k, logic [7:0] b);
            int p;
            if (k == KIND_ABORT) begin
                if (!in_frame) return 1'b0;
                close_frame(1'b0, ST_SHORT);
                return 1'b1;
            end
            if (!in_frame) begin
                if (b == sync_val) begin
                    in_frame = 1'b1;
                    pos      = POS_W'(1);
                    sum      = 8'h00;
                    return 1'b1;
                end
                return 1'b0;
            end
            p = pos;
            if (p >= 1 && p <= LAST_MOTION_POS) begin
                if (p % 2 == 1) hold = b;
                else words[(p - 2) / 2] = {hold, b};
            end else if (p == TEMP_HIGH_POS) begin
                hold = b;
            end else if (p == TEMP_LOW_POS) begin
                words[NUM_WORDS-1] = {hold, b};
            end
            if (p >= FRAME_BYTES - 1) begin
                close_frame(1'b1, (sum == b) ? ST_GOOD : ST_BAD_SUM);
                return 1'b1;
            end
            sum = sum + b;
            pos = POS_W'(p + 1);
            return 1'b1;
        endfunction

        function void check_result(decoded_t act);
            decoded_t want;
            if (pending.size() == 0) begin
                $error("result with no frame pending: status %0d", act.status);
                errors++;
                return;
            end
            want = pending.pop_front();
            foreach (want.word[i]) begin
                if (act.word[i] !== want.word[i]) begin
                    $error("%s: expected 0x%04h, actual 0x%04h",
                           names[i], want.word[i], act.word[i]);
                    errors++;
                end
            end
            if (act.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, act.status);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ahrs_in_if  in_ch ();
    ahrs_cfg_if cfg_ch ();
    ahrs_res_if res_ch ();

    ahrs_frame_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    frame_scoreboard sb;
    decoded_t        seen_frame;
    int              src_idle_pct = 0;
    int              snk_idle_pct = 0;
    int              frame_items = 0;
    int              results_seen = 0;
    int              cycle_count = 0;
    int              hold_left = 0;
    bit              hold_done = 1'b0;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ahrs_frame_decoder_core test failed");
            $finish;
        end
    end

    // receiver: random ready, one long hold-off once results start flowing
    always @(negedge i_clk) begin
        if (!hold_done && results_seen >= HOLD_AFTER_RES) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            seen_frame.word[0] = res_ch.roll;
            seen_frame.word[1] = res_ch.pitch;
            seen_frame.word[2] = res_ch.yaw;
            seen_frame.word[3] = res_ch.roll_rate;
            seen_frame.word[4] = res_ch.pitch_rate;
            seen_frame.word[5] = res_ch.yaw_rate;
            seen_frame.word[6] = res_ch.accel_x;
            seen_frame.word[7] = res_ch.accel_y;
            seen_frame.word[8] = res_ch.accel_z;
            seen_frame.word[9] = res_ch.temperature_code;
            seen_frame.status  = t_status'(res_ch.status);
            sb.check_result(seen_frame);
            results_seen++;
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input logic k, input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= k;
        in_ch.data_byte <= b;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        frame_items += sb.note_input(k, b);
    endtask

    task automatic write_sync(input logic [7:0] v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.set_sync(v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // cut < 0 sends the whole frame; otherwise abort after cut bytes past sync
    task automatic send_frame(input int cut, input bit corrupt, input int style);
        logic [7:0] body [FRAME_BYTES];
        logic [7:0] pattern [8];
        logic [7:0] csum;
        int         i;
        pattern = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
        csum = 8'h00;
        for (i = 1; i <= FRAME_BYTES - 2; i++) begin
            if (style == STYLE_PATTERN) body[i] = pattern[(i - 1) % 8];
            else if (style == STYLE_ALLSYNC) body[i] = sb.sync_val;
            else body[i] = rand_byte();
            csum = csum + body[i];
        end
        send_item(KIND_DATA, sb.sync_val);
        for (i = 1; i <= FRAME_BYTES - 2; i++) begin
            if (cut == i - 1) begin
                send_item(KIND_ABORT, rand_byte());
                return;
            end
            send_item(KIND_DATA, body[i]);
        end
        if (cut >= 0) begin
            send_item(KIND_ABORT, rand_byte());
            return;
        end
        if (corrupt) csum = csum ^ 8'($urandom_range(1, 255));
        send_item(KIND_DATA, csum);
    endtask

    // close any open frame and wait for the block to go quiet
    task automatic settle();
        if (sb.in_frame) send_item(KIND_ABORT, rand_byte());
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n_items);
        int r;
        int start;
        start = frame_items;
        while (frame_items - start < n_items) begin
            r = $urandom_range(99);
            if (r < 62) begin
                send_frame(-1, 1'b0, STYLE_RANDOM);
            end else if (r < 78) begin
                send_frame(-1, 1'b1, STYLE_RANDOM);
            end else if (r < 90) begin
                send_frame($urandom_range(FRAME_BYTES - 2), 1'b0, STYLE_RANDOM);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
            end
        end
    endtask

    initial begin
        logic [7:0] sync_plan [NUM_PHASES];
        int         ph;
        sb = new();
        sync_plan = '{8'h00, 8'hFF, 8'h5A, 8'($urandom_range(255)), 8'h80,
                      8'($urandom_range(255))};
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_DATA;
        in_ch.data_byte = 8'h00;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = 8'h00;
        res_ch.ready    = 1'b0;
        src_idle_pct    = 27;
        snk_idle_pct    = 75;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset sync value, abort while hunting, short frame, extremes
        send_item(KIND_ABORT, 8'hFF);
        send_item(KIND_DATA, 8'h00);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_ABORT, 8'h00);
        send_frame(-1, 1'b0, STYLE_PATTERN);
        send_frame(-1, 1'b1, STYLE_ALLSYNC);
        settle();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 2)
                0: begin
                    src_idle_pct = 27;
                    snk_idle_pct = 75;
                end
                1: begin
                    src_idle_pct = 75;
                    snk_idle_pct = 27;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            write_sync(sync_plan[ph]);
            run_phase(PHASE_ITEMS);
            settle();
        end

        if (sb.errors == 0) begin
            $display("ahrs_frame_decoder_core test passed");
        end else begin
            $display("ahrs_frame_decoder_core test failed");
        end
        $finish;
    end

endmodule
